// ----- rtl/integer_matrix_multiply_defines.svh -----
// Assertion macros for the integer matrix multiply block.
// Used by the top level only; no other dependencies.
`ifndef INTEGER_MATRIX_MULTIPLY_DEFINES_SVH
`define INTEGER_MATRIX_MULTIPLY_DEFINES_SVH
// Check that a condition implies a consequence on the same edge.
`define IMM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication failed");
// Check that a condition implies a consequence on the next edge.
`define IMM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");
`endif

// ----- rtl/imm_pkg.sv -----
// Package for the integer matrix multiply block: sizes, codes, queue entry type.
// No dependencies.
`timescale 1ns / 1ps
package imm_pkg;
	localparam int MAX_DIM_DEF = 16;
	localparam int SIZE_W = 5;
	localparam int IDX_W = 4;
	localparam int ELEM_W = 16;
	localparam int SUM_W = 36;
	localparam int PROD_W = 32;
	localparam int CFG_IDX_W = 2;
	localparam int DIM_LIMIT = 16;

	localparam logic [1:0] ACT_LOAD_A = 2'd0;
	localparam logic [1:0] ACT_LOAD_B = 2'd1;
	localparam logic [1:0] ACT_COMPUTE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INNER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS_B = 2'd2;

	// One compute job handed from the front to the back.
	typedef struct packed {
		logic [IDX_W-1:0] row;
		logic             bad;
	} job_t;

	// Saturate a size register to 1..lim.
	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
			input logic [SIZE_W-1:0] lim);
		logic [SIZE_W-1:0] r;
		r = v;
		if (v == '0) r = SIZE_W'(1);
		else if (v > lim) r = lim;
		return r;
	endfunction
endpackage

// ----- rtl/imm_front.sv -----
// Front end: takes transactions, writes element stores, queues compute jobs.
// Depends on imm_pkg.
`timescale 1ns / 1ps
module imm_front #(
	parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF,
	parameter int AW = $clog2(MAX_DIM * MAX_DIM)
) (
	input  logic                       take,
	input  logic [1:0]                 action,
	input  logic [imm_pkg::IDX_W-1:0]  row_index,
	input  logic [imm_pkg::IDX_W-1:0]  col_index,
	input  logic [imm_pkg::SIZE_W-1:0] m_eff,
	input  logic [imm_pkg::SIZE_W-1:0] p_eff,
	input  logic [imm_pkg::SIZE_W-1:0] n_eff,
	output logic                       wr_a,
	output logic                       wr_b,
	output logic [AW-1:0]              wr_addr,
	output logic                       job_push,
	output imm_pkg::job_t              job
);
	import imm_pkg::*;
	logic row_lt_m, row_lt_p, col_lt_p, col_lt_n;
	logic [AW-1:0] lin;

	assign row_lt_m = {1'b0, row_index} < m_eff;
	assign row_lt_p = {1'b0, row_index} < p_eff;
	assign col_lt_p = {1'b0, col_index} < p_eff;
	assign col_lt_n = {1'b0, col_index} < n_eff;
	assign lin = AW'(row_index) * AW'(MAX_DIM) + AW'(col_index);
	assign wr_addr = lin;

	always_comb begin
		wr_a = 1'b0;
		wr_b = 1'b0;
		job_push = 1'b0;
		if (take) begin
			unique case (action)
				ACT_LOAD_A: wr_a = row_lt_m && col_lt_p;
				ACT_LOAD_B: wr_b = row_lt_p && col_lt_n;
				ACT_COMPUTE: job_push = 1'b1;
				default: ;
			endcase
		end
	end
	assign job.row = row_index;
	assign job.bad = !row_lt_m;
endmodule

// ----- rtl/imm_back.sv -----
// Back end: walks one result row, one multiply-accumulate per cycle.
// Depends on imm_pkg; reads the element stores it owns.
`timescale 1ns / 1ps
module imm_back #(
	parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF,
	parameter int AW = $clog2(MAX_DIM * MAX_DIM)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_a,
	input  logic                       wr_b,
	input  logic [AW-1:0]              wr_addr,
	input  logic [imm_pkg::ELEM_W-1:0] wr_data,
	input  logic                       job_valid,
	input  imm_pkg::job_t              job,
	input  logic [imm_pkg::SIZE_W-1:0] p_eff,
	input  logic [imm_pkg::SIZE_W-1:0] n_eff,
	output logic                       job_pop,
	output logic                       active,
	output logic                       strobe,
	output logic [imm_pkg::IDX_W-1:0]  out_row,
	output logic [imm_pkg::IDX_W-1:0]  out_col,
	output logic signed [imm_pkg::SUM_W-1:0] dot_sum,
	output logic                       last,
	output logic                       bad_row
);
	import imm_pkg::*;
	typedef enum logic [1:0] {IDLE, RUN} state_t;
	state_t state_q;
	logic [ELEM_W-1:0] mem_a [MAX_DIM*MAX_DIM];
	logic [ELEM_W-1:0] mem_b [MAX_DIM*MAX_DIM];
	logic [IDX_W-1:0] row_q, k_q, c_q;
	// read stage
	logic signed [ELEM_W-1:0] a_s1, b_s1;
	logic v_s1, end_s1, first_s1, lastc_s1;
	logic [IDX_W-1:0] col_s1;
	// multiply stage
	logic signed [PROD_W-1:0] prod_s2;
	logic v_s2, end_s2, first_s2, lastc_s2;
	logic [IDX_W-1:0] col_s2;
	logic signed [SUM_W-1:0] acc_q;
	logic k_end, c_end;
	logic [AW-1:0] ra, rb;

	assign k_end = {1'b0, k_q} == p_eff - SIZE_W'(1);
	assign c_end = {1'b0, c_q} == n_eff - SIZE_W'(1);
	assign ra = AW'(row_q) * AW'(MAX_DIM) + AW'(k_q);
	assign rb = AW'(k_q) * AW'(MAX_DIM) + AW'(c_q);
	assign job_pop = (state_q == IDLE) && job_valid && !job.bad;
	assign active = (state_q == RUN) || v_s1 || v_s2;

	always_ff @(posedge clk) begin
		if (wr_a) mem_a[wr_addr] <= wr_data;
		if (wr_b) mem_b[wr_addr] <= wr_data;
		a_s1 <= mem_a[ra];
		b_s1 <= mem_b[rb];
		prod_s2 <= PROD_W'(a_s1) * PROD_W'(b_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			row_q <= '0; k_q <= '0; c_q <= '0;
			v_s1 <= 1'b0; v_s2 <= 1'b0;
			end_s1 <= 1'b0; end_s2 <= 1'b0;
			first_s1 <= 1'b0; first_s2 <= 1'b0;
			lastc_s1 <= 1'b0; lastc_s2 <= 1'b0;
			col_s1 <= '0; col_s2 <= '0;
			acc_q <= '0;
			strobe <= 1'b0; out_row <= '0; out_col <= '0;
			dot_sum <= '0; last <= 1'b0; bad_row <= 1'b0;
		end else begin
			strobe <= 1'b0;
			v_s1 <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (job_valid && job.bad) begin
						// flagged row: answer at once
						strobe <= 1'b1; out_row <= job.row; out_col <= '0;
						dot_sum <= '0; last <= 1'b1; bad_row <= 1'b1;
					end else if (job_valid) begin
						row_q <= job.row; k_q <= '0; c_q <= '0;
						state_q <= RUN;
					end
				end
				RUN: begin
					v_s1 <= 1'b1;
					end_s1 <= k_end;
					first_s1 <= k_q == '0;
					lastc_s1 <= c_end;
					col_s1 <= c_q;
					if (k_end) begin
						k_q <= '0;
						c_q <= c_q + IDX_W'(1);
						if (c_end) state_q <= IDLE;
					end else k_q <= k_q + IDX_W'(1);
				end
				default: state_q <= IDLE;
			endcase
			v_s2 <= v_s1; end_s2 <= end_s1; first_s2 <= first_s1;
			lastc_s2 <= lastc_s1; col_s2 <= col_s1;
			if (v_s2) begin
				if (first_s2) acc_q <= SUM_W'(prod_s2);
				else acc_q <= acc_q + SUM_W'(prod_s2);
				if (end_s2) begin
					strobe <= 1'b1; out_row <= row_q; out_col <= col_s2;
					dot_sum <= first_s2 ? SUM_W'(prod_s2) : acc_q + SUM_W'(prod_s2);
					last <= lastc_s2; bad_row <= 1'b0;
				end
			end
		end
	end
endmodule

// ----- rtl/imm_queue.sv -----
// Two-entry job queue between front and back.
// Depends on imm_pkg.
`timescale 1ns / 1ps
module imm_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  imm_pkg::job_t din,
	input  logic          pop,
	output logic          valid,
	output logic          full,
	output imm_pkg::job_t dout
);
	import imm_pkg::*;
	job_t mem_q [2];
	logic rp_q, wp_q;
	logic [1:0] cnt_q;
	assign valid = cnt_q != 2'd0;
	assign full = cnt_q == 2'd2;
	assign dout = mem_q[rp_q];
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= din;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q <= 1'b0; wp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// ----- rtl/integer_matrix_multiply.sv -----
// Top level of the integer matrix multiply block: config registers, front, queue, back.
// Depends on imm_pkg, imm_front, imm_queue, imm_back and the defines header.
//
// Usage: drive action/row_index/col_index/element with start; a transaction is
// taken on an edge with start high and busy low. Load A/B writes one element
// into the on-chip stores and gives no result; out-of-range loads are
// dropped. A compute transaction queues a row job. The back end runs one
// multiply-accumulate per cycle over inner_size * cols_b products per row
// (up to 256), with registered store reads, products and outputs;
// results come with strobe for one cycle each, in column order, last on the
// final column. A compute of a row beyond rows_a gives one flagged result,
// through the queue and the output register, once the back end is idle.
// busy rises while the job queue is full or a load would land in a store being
// read; loads wait behind queued and running rows, computes queue two deep.
// The receiver cannot stall: every strobe cycle is a delivered result.
// Config writes (cfg_we, cfg_index, cfg_data) take effect at once and must
// happen only while idle. Reset sets all sizes to 1 and empties the queue;
// the stores are left undefined until loaded.
`timescale 1ns / 1ps
`include "integer_matrix_multiply_defines.svh"
module integer_matrix_multiply #(
	parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  action,
	input  logic [imm_pkg::IDX_W-1:0]   row_index,
	input  logic [imm_pkg::IDX_W-1:0]   col_index,
	input  logic signed [imm_pkg::ELEM_W-1:0] element,
	input  logic                        cfg_we,
	input  logic [imm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [imm_pkg::SIZE_W-1:0]  cfg_data,
	output logic                        strobe,
	output logic [imm_pkg::IDX_W-1:0]   out_row,
	output logic [imm_pkg::IDX_W-1:0]   out_col,
	output logic signed [imm_pkg::SUM_W-1:0] dot_sum,
	output logic                        last,
	output logic                        bad_row
);
	import imm_pkg::*;
	localparam int AW = $clog2(MAX_DIM * MAX_DIM);
	// largest usable size: the store side and the index width both bound it
	localparam int DIM_LIM = (MAX_DIM < DIM_LIMIT) ? MAX_DIM : DIM_LIMIT;

	logic [SIZE_W-1:0] rows_a_q, inner_q, cols_q, m_eff, p_eff, n_eff;
	logic take, wr_a, wr_b, job_push, job_pop, q_valid, q_full, back_active;
	logic [AW-1:0] wr_addr;
	job_t job_in, job_out;

	// hold the size registers; clamp to the supported range on use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q <= SIZE_W'(1); inner_q <= SIZE_W'(1); cols_q <= SIZE_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ROWS_A: rows_a_q <= cfg_data;
				CFG_INNER: inner_q <= cfg_data;
				CFG_COLS_B: cols_q <= cfg_data;
				default: ;
			endcase
		end
	end
	assign m_eff = eff_size(rows_a_q, SIZE_W'(DIM_LIM));
	assign p_eff = eff_size(inner_q, SIZE_W'(DIM_LIM));
	assign n_eff = eff_size(cols_q, SIZE_W'(DIM_LIM));

	// stall on a full queue, and hold loads until queued and running rows are done
	assign busy = q_full || (start && action != ACT_COMPUTE && (q_valid || back_active));
	assign take = start && !busy;

	imm_front #(.MAX_DIM(MAX_DIM), .AW(AW)) u_front (
		.take, .action, .row_index, .col_index,
		.m_eff, .p_eff, .n_eff, .wr_a, .wr_b, .wr_addr, .job_push, .job(job_in)
	);

	imm_queue u_queue (
		.clk, .arst_n, .push(job_push), .din(job_in), .pop(job_pop || (q_valid &&
			job_out.bad && !back_active)), .valid(q_valid), .full(q_full), .dout(job_out)
	);

	imm_back #(.MAX_DIM(MAX_DIM), .AW(AW)) u_back (
		.clk, .arst_n, .wr_a, .wr_b, .wr_addr, .wr_data(element),
		.job_valid(q_valid && !back_active), .job(job_out), .p_eff, .n_eff,
		.job_pop, .active(back_active), .strobe, .out_row, .out_col, .dot_sum,
		.last, .bad_row
	);

	`IMM_ASSERT_IMPL(a_bad_is_last, clk, arst_n, strobe && bad_row, last && dot_sum == '0)
	`IMM_ASSERT_IMPL(a_no_push_full, clk, arst_n, job_push, !q_full)
	`IMM_ASSERT_NEXT(a_take_clears, clk, arst_n, !q_valid && !back_active && !job_push, !q_full)
endmodule
